### hw/rtl/gsa_pkg.sv
package gsa_pkg;

  localparam int unsigned SlotCountDefault = 64;

  localparam logic [1:0] CMD_INIT     = 2'd0;
  localparam logic [1:0] CMD_ALLOCATE = 2'd1;
  localparam logic [1:0] CMD_RETIRE   = 2'd2;
  localparam logic [1:0] CMD_COLLECT  = 2'd3;

  localparam logic [1:0] ST_AVAILABLE = 2'd0;
  localparam logic [1:0] ST_ALLOCATED = 2'd1;
  localparam logic [1:0] ST_RETIRED   = 2'd2;
  localparam logic [1:0] ST_SEALED    = 2'd3;

  localparam logic [31:0] GenMax = 32'hFFFF_FFFF;
  localparam logic [31:0] GenOne = 32'd1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] gen;
  } slot_entry_t;

  typedef struct packed {
    logic accept;
    logic fill;
    logic rd;
    logic eval;
    logic publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_init;
    logic skip;
    logic cnt_last;
    logic eval_done;
    logic out_free;
  } ctl_sts_t;

endpackage

### hw/rtl/gsa_if.sv
interface gsa_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] handle_slot;
  logic [31:0] handle_generation;
  logic [63:0] frame_number;

  modport source (
    output valid, command, handle_slot, handle_generation, frame_number,
    input  ready
  );
  modport sink (
    input  valid, command, handle_slot, handle_generation, frame_number,
    output ready
  );
endinterface

interface gsa_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [5:0]  granted_slot;
  logic [31:0] granted_generation;
  logic [6:0]  freed_count;
  logic [6:0]  sealed_total;

  modport source (
    output valid, ok, granted_slot, granted_generation, freed_count, sealed_total,
    input  ready
  );
  modport sink (
    input  valid, ok, granted_slot, granted_generation, freed_count, sealed_total,
    output ready
  );
endinterface

interface gsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_generation;

  modport source (
    output valid, start_generation,
    input  ready
  );
  modport sink (
    input  valid, start_generation,
    output ready
  );
endinterface

### hw/rtl/gsa_controller.sv
module gsa_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  gsa_pkg::ctl_sts_t sts_i,
  output gsa_pkg::ctl_cmd_t cmd_o
);
  import gsa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       resp_q, resp_d;

  always_comb begin
    state_d      = state_q;
    resp_d       = resp_q;
    cmd_o        = '0;
    item_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.fill = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = resp_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_init) begin
            state_d = S_CLEAR;
            resp_d  = 1'b1;
          end else if (sts_i.skip) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.eval_done ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.publish = 1'b1;
          resp_d        = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      resp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      resp_q  <= resp_d;
    end
  end

endmodule

### hw/rtl/gsa_datapath.sv
module gsa_datapath #(
  parameter int unsigned SlotCount = gsa_pkg::SlotCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gsa_pkg::ctl_cmd_t cmd_i,
  output gsa_pkg::ctl_sts_t sts_o,
  input  logic [1:0]        command_i,
  input  logic [31:0]       handle_slot_i,
  input  logic [31:0]       handle_generation_i,
  input  logic [63:0]       frame_number_i,
  input  logic              cfg_valid_i,
  input  logic [31:0]       cfg_start_generation_i,
  input  logic              result_ready_i,
  output logic              result_valid_o,
  output logic              ok_o,
  output logic [5:0]        granted_slot_o,
  output logic [31:0]       granted_generation_o,
  output logic [6:0]        freed_count_o,
  output logic [6:0]        sealed_total_o
);
  import gsa_pkg::*;

  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW = $clog2(SlotCount + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(SlotCount);

  slot_entry_t entry_mem [SlotCount];
  logic [63:0] frame_mem [SlotCount];

  logic [31:0]     start_gen_q;
  logic [31:0]     fill_gen_q;
  logic [IdxW-1:0] cnt_q;
  logic [CntW-1:0] hint_q;
  logic [CntW-1:0] sealed_q;
  logic            out_valid_q;

  logic [1:0]      command_q;
  logic [31:0]     hgen_q;
  logic [63:0]     frame_q;
  slot_entry_t     entry_rd_q;
  logic [63:0]     frame_rd_q;
  logic            res_ok_q;
  logic [IdxW-1:0] res_slot_q;
  logic [31:0]     res_gen_q;
  logic [CntW-1:0] res_recl_q;
  logic            ok_q;
  logic [5:0]      slot_q;
  logic [31:0]     gen_q;
  logic [6:0]      recl_q;
  logic [6:0]      sealed_out_q;

  slot_entry_t wr_entry;
  slot_entry_t mem_wdata;
  logic        mem_we;
  logic        frame_we;
  logic        eval_done;
  logic        grant;
  logic        retire_hit;
  logic        reclaim;
  logic        seal;

  always_comb begin
    wr_entry   = entry_rd_q;
    eval_done  = 1'b1;
    grant      = 1'b0;
    retire_hit = 1'b0;
    reclaim    = 1'b0;
    seal       = 1'b0;
    case (command_q)
      CMD_ALLOCATE: begin
        if (entry_rd_q.status == ST_AVAILABLE) begin
          grant           = 1'b1;
          wr_entry.status = ST_ALLOCATED;
        end else begin
          eval_done = (cnt_q == LastIdx);
        end
      end
      CMD_RETIRE: begin
        if (entry_rd_q.status == ST_ALLOCATED && entry_rd_q.gen == hgen_q) begin
          retire_hit      = 1'b1;
          wr_entry.status = ST_RETIRED;
        end
      end
      CMD_COLLECT: begin
        eval_done = (cnt_q == LastIdx);
        if (entry_rd_q.status == ST_RETIRED && frame_q >= frame_rd_q) begin
          if (entry_rd_q.gen == GenMax) begin
            seal            = 1'b1;
            wr_entry.status = ST_SEALED;
          end else begin
            reclaim         = 1'b1;
            wr_entry.status = ST_AVAILABLE;
            wr_entry.gen    = entry_rd_q.gen + GenOne;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_we   = cmd_i.fill || (cmd_i.eval && (grant || retire_hit || reclaim || seal));
  assign frame_we = cmd_i.eval && retire_hit;
  assign mem_wdata = cmd_i.fill ? slot_entry_t'{status: ST_AVAILABLE, gen: fill_gen_q}
                                : wr_entry;

  always_comb begin
    sts_o.is_init   = (command_i == CMD_INIT);
    sts_o.skip      = (command_i == CMD_ALLOCATE && hint_q == CntFull) ||
                      (command_i == CMD_RETIRE &&
                       (handle_generation_i == 32'd0 || handle_slot_i >= 32'(SlotCount)));
    sts_o.cnt_last  = (cnt_q == LastIdx);
    sts_o.eval_done = eval_done;
    sts_o.out_free  = !out_valid_q || result_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_gen_q <= GenOne;
      fill_gen_q  <= GenOne;
      cnt_q       <= '0;
      hint_q      <= '0;
      sealed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        start_gen_q <= cfg_start_generation_i;
      end
      if (cmd_i.accept) begin
        case (command_i)
          CMD_INIT: begin
            cnt_q      <= '0;
            fill_gen_q <= (start_gen_q == 32'd0) ? GenOne : start_gen_q;
            sealed_q   <= '0;
            hint_q     <= '0;
          end
          CMD_ALLOCATE: begin
            cnt_q <= IdxW'(hint_q);
          end
          CMD_RETIRE: begin
            cnt_q <= handle_slot_i[IdxW-1:0];
          end
          default: begin
            cnt_q <= '0;
          end
        endcase
      end
      if (cmd_i.fill) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.eval) begin
        if (command_q == CMD_ALLOCATE) begin
          if (grant) begin
            hint_q <= CntW'(cnt_q) + 1'b1;
          end else if (cnt_q == LastIdx) begin
            hint_q <= CntFull;
          end
        end
        if (reclaim && CntW'(cnt_q) < hint_q) begin
          hint_q <= CntW'(cnt_q);
        end
        if (seal) begin
          sealed_q <= sealed_q + 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      command_q  <= command_i;
      hgen_q     <= handle_generation_i;
      frame_q    <= frame_number_i;
      res_ok_q   <= (command_i == CMD_INIT) || (command_i == CMD_COLLECT);
      res_slot_q <= '0;
      res_gen_q  <= '0;
      res_recl_q <= '0;
    end
    if (cmd_i.eval) begin
      if (grant) begin
        res_ok_q   <= 1'b1;
        res_slot_q <= cnt_q;
        res_gen_q  <= entry_rd_q.gen;
      end
      if (retire_hit) begin
        res_ok_q <= 1'b1;
      end
      if (reclaim) begin
        res_recl_q <= res_recl_q + 1'b1;
      end
    end
    if (cmd_i.publish) begin
      ok_q         <= res_ok_q;
      slot_q       <= 6'(res_slot_q);
      gen_q        <= res_gen_q;
      recl_q       <= 7'(res_recl_q);
      sealed_out_q <= 7'(sealed_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      entry_rd_q <= entry_mem[cnt_q];
      frame_rd_q <= frame_mem[cnt_q];
    end
    if (mem_we) begin
      entry_mem[cnt_q] <= mem_wdata;
    end
    if (frame_we) begin
      frame_mem[cnt_q] <= frame_q;
    end
  end

  assign result_valid_o       = out_valid_q;
  assign ok_o                 = ok_q;
  assign granted_slot_o       = slot_q;
  assign granted_generation_o = gen_q;
  assign freed_count_o        = recl_q;
  assign sealed_total_o       = sealed_out_q;

endmodule

### hw/rtl/generational_slot_allocator.sv
// Generational slot allocator: hands out slots as (index, generation) handles, takes them
// back on retire with the frame that last uses them, and on collect returns every retired
// slot whose frame has completed with its generation bumped, or seals it for good once the
// generation is at its maximum. Slot state lives in two single-port memories (status with
// generation, and retire frame) that a controller walks one entry at a time, reading each
// entry and then evaluating it, so timing is set by that read-then-write loop. Retire skips
// the slot read when the handle is out of range or has generation zero. Allocate starts at
// a hint below which no slot is available and examines slots from there until one is
// available or the last is done; with the hint past the end it fails without reading any
// slot. Collect examines and init rewrites every slot. After reset a clearing pass sets
// every slot to available with generation one; no word is accepted meanwhile, though
// configuration writes are. The result register lets a finished word wait for the
// consumer while the next word is accepted; the start generation register is always ready.
module generational_slot_allocator #(
  parameter int unsigned SlotCount = gsa_pkg::SlotCountDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  gsa_cfg_if.sink      cfg_i,
  gsa_item_if.sink     item_i,
  gsa_result_if.source result_o
);
  import gsa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_i.ready = 1'b1;

  gsa_controller u_controller (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  gsa_datapath #(
    .SlotCount (SlotCount)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .command_i              (item_i.command),
    .handle_slot_i          (item_i.handle_slot),
    .handle_generation_i    (item_i.handle_generation),
    .frame_number_i         (item_i.frame_number),
    .cfg_valid_i            (cfg_i.valid),
    .cfg_start_generation_i (cfg_i.start_generation),
    .result_ready_i         (result_o.ready),
    .result_valid_o         (result_o.valid),
    .ok_o                   (result_o.ok),
    .granted_slot_o         (result_o.granted_slot),
    .granted_generation_o   (result_o.granted_generation),
    .freed_count_o          (result_o.freed_count),
    .sealed_total_o         (result_o.sealed_total)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("word accepted while a previous word was still in progress");

  a_publish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> sts.out_free)
    else $error("result published over an unread result");

  a_valid_from_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(cmd.publish))
    else $error("result valid raised without a publish");

  a_fill_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill |-> !item_i.ready)
    else $error("input ready during the clearing pass");

endmodule
